// File: rtl/keypad_scan_debounce_macros.svh
// assertion macros shared by the keypad scanner checker
`ifndef KEYPAD_SCAN_DEBOUNCE_MACROS_SVH
`define KEYPAD_SCAN_DEBOUNCE_MACROS_SVH

// property checked at every clock edge outside reset
`define KSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition in one cycle implies a consequence in the next cycle
`define KSD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/ksd_pkg.sv
// shared types, constants and helper functions of the keypad scanner
`default_nettype none

package ksd_pkg;

  localparam int unsigned CNT_W  = 6;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned CHAR_W = 7;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // reset values of the two timing registers
  localparam logic [CNT_W-1:0] DEB_TICKS_RST = 6'd32;
  localparam logic [CNT_W-1:0] REL_TICKS_RST = 6'd32;
  localparam logic [CNT_W-1:0] DEB_TICKS_MIN = 6'd1;
  localparam logic [CNT_W-1:0] DEB_TICKS_MAX = 6'd62;
  localparam logic [CNT_W-1:0] REL_TICKS_MIN = 6'd1;

  // request commands
  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_ACK  = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_RELEASE  = 1'b1;

  // line level meaning a closed key
  localparam logic LINE_PRESSED = 1'b0;

  localparam logic [CHAR_W-1:0] ASCII_ZERO   = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_A_BASE = 7'd55;
  localparam logic [POS_W-1:0]  DEC_LIMIT    = 4'd10;

  // configuration seen by the scan logic
  typedef struct packed {
    logic [CNT_W-1:0] deb_ticks;
    logic [CNT_W-1:0] rel_ticks;
    logic             deb_load;
    logic             rel_load;
    logic [CNT_W-1:0] wdata;
  } ksd_cfg_t;

  // status carried from the scan logic to the result register
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             key_valid;
    logic [POS_W-1:0] key;
    logic             released;
    logic             buzzer;
  } ksd_status_t;

  // debounce length clamped to 1..62
  function automatic logic [CNT_W-1:0] eff_debounce(input logic [CNT_W-1:0] ticks);
    logic [CNT_W-1:0] d;
    d = ticks;
    if (d < DEB_TICKS_MIN) d = DEB_TICKS_MIN;
    if (d > DEB_TICKS_MAX) d = DEB_TICKS_MAX;
    return d;
  endfunction

  // release length, zero used as one
  function automatic logic [CNT_W-1:0] eff_release(input logic [CNT_W-1:0] ticks);
    return (ticks < REL_TICKS_MIN) ? REL_TICKS_MIN : ticks;
  endfunction

  // ascii hex digit of a key index
  function automatic logic [CHAR_W-1:0] hex_char(input logic [POS_W-1:0] k);
    return (k < DEC_LIMIT) ? ASCII_ZERO + CHAR_W'(k) : ASCII_A_BASE + CHAR_W'(k);
  endfunction

endpackage

`default_nettype wire

// File: rtl/ksd_if.sv
// request and result channel interfaces of the keypad scanner
`default_nettype none

// scan tick or acknowledge request
interface ksd_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic line_level;

  modport source (output valid, output cmd, output line_level, input ready);
  modport sink (input valid, input cmd, input line_level, output ready);
endinterface

// status result
interface ksd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] drive_row;
  logic [1:0] sense_column;
  logic       key_valid;
  logic [3:0] key_index;
  logic [6:0] key_char;
  logic       key_released;
  logic       buzzer_on;

  modport source (output valid, output drive_row, output sense_column, output key_valid,
                  output key_index, output key_char, output key_released,
                  output buzzer_on, input ready);
  modport sink (input valid, input drive_row, input sense_column, input key_valid,
                input key_index, input key_char, input key_released,
                input buzzer_on, output ready);
endinterface

`default_nettype wire

// File: rtl/ksd_regs.sv
// apb register file holding the debounce and release lengths
`default_nettype none

module ksd_regs
  import ksd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output ksd_cfg_t               cfg_o
);

  logic [CNT_W-1:0] deb_ticks_q;
  logic [CNT_W-1:0] rel_ticks_q;
  logic             wr_en;
  logic             reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_ticks_q <= DEB_TICKS_RST;
      rel_ticks_q <= REL_TICKS_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_DEBOUNCE: deb_ticks_q <= pwdata[CNT_W-1:0];
        REG_RELEASE:  rel_ticks_q <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_sel)
      REG_DEBOUNCE: prdata = DATA_W'(deb_ticks_q);
      REG_RELEASE:  prdata = DATA_W'(rel_ticks_q);
      default:      prdata = '0;
    endcase
  end

  // configuration view for the scan logic, with reload strobes
  assign cfg_o.deb_ticks = deb_ticks_q;
  assign cfg_o.rel_ticks = rel_ticks_q;
  assign cfg_o.deb_load  = wr_en && (reg_sel == REG_DEBOUNCE);
  assign cfg_o.rel_load  = wr_en && (reg_sel == REG_RELEASE);
  assign cfg_o.wdata     = pwdata[CNT_W-1:0];

endmodule

`default_nettype wire

// File: rtl/ksd_scan.sv
// scan position, debounce and release counters and key flags
`default_nettype none

module ksd_scan
  import ksd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ksd_cfg_t    cfg_i,
  input  wire logic        accept_i,
  input  wire logic        cmd_i,
  input  wire logic        line_level_i,
  output ksd_status_t      status_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] dc_q, dc_d;
  logic [CNT_W-1:0] rc_q, rc_d;
  logic [POS_W-1:0] key_q, key_d;
  logic             ready_q, ready_d;
  logic             released_q, released_d;
  logic             buzzer_q, buzzer_d;

  logic [CNT_W-1:0] deb_eff;
  logic [CNT_W-1:0] idle_val;
  logic [CNT_W-1:0] rel_eff;
  logic [CNT_W-1:0] dc_dec;
  logic [CNT_W-1:0] rc_dec;
  logic             pressed;

  assign deb_eff  = eff_debounce(cfg_i.deb_ticks);
  assign idle_val = deb_eff + CNT_W'(1);
  assign rel_eff  = eff_release(cfg_i.rel_ticks);
  assign dc_dec   = dc_q - CNT_W'(1);
  assign rc_dec   = rc_q - CNT_W'(1);
  assign pressed  = (line_level_i == LINE_PRESSED);

  // next state for one request
  always_comb begin
    pos_d      = pos_q;
    dc_d       = dc_q;
    rc_d       = rc_q;
    key_d      = key_q;
    ready_d    = ready_q;
    released_d = released_q;
    buzzer_d   = buzzer_q;
    if (cmd_i == CMD_SCAN) begin
      if (ready_q) begin
        // release detection
        if (pressed) begin
          rc_d = rel_eff;
        end else if (rc_dec == '0) begin
          released_d = 1'b1;
          buzzer_d   = 1'b0;
          rc_d       = rel_eff;
        end else begin
          rc_d = rc_dec;
        end
      end else if (dc_q == idle_val) begin
        // idle: first press latches the key
        if (pressed) begin
          dc_d  = deb_eff;
          key_d = pos_q;
        end
      end else begin
        // debounce countdown
        if (dc_dec == '0) begin
          if (pressed) begin
            ready_d  = 1'b1;
            buzzer_d = 1'b1;
          end
          dc_d = idle_val;
        end else begin
          dc_d = dc_dec;
        end
      end
      pos_d = pos_q + POS_W'(1);
    end else if (released_q) begin
      // acknowledge after release
      ready_d    = 1'b0;
      released_d = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      dc_q       <= eff_debounce(DEB_TICKS_RST) + CNT_W'(1);
      rc_q       <= eff_release(REL_TICKS_RST);
      key_q      <= '0;
      ready_q    <= 1'b0;
      released_q <= 1'b0;
      buzzer_q   <= 1'b0;
    end else begin
      if (accept_i) begin
        pos_q      <= pos_d;
        key_q      <= key_d;
        ready_q    <= ready_d;
        released_q <= released_d;
        buzzer_q   <= buzzer_d;
      end
      // register writes reload the counters
      if (cfg_i.deb_load) begin
        dc_q <= eff_debounce(cfg_i.wdata) + CNT_W'(1);
      end else if (accept_i) begin
        dc_q <= dc_d;
      end
      if (cfg_i.rel_load) begin
        rc_q <= eff_release(cfg_i.wdata);
      end else if (accept_i) begin
        rc_q <= rc_d;
      end
    end
  end

  // status after this request
  assign status_o.pos       = pos_d;
  assign status_o.key_valid = ready_d;
  assign status_o.key       = key_d;
  assign status_o.released  = released_d;
  assign status_o.buzzer    = buzzer_d;

endmodule

`default_nettype wire

// File: rtl/ksd_result.sv
// result register with ready generation toward the request side
`default_nettype none

module ksd_result
  import ksd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire ksd_status_t status_i,
  output logic             in_ready_o,
  ksd_out_if.source        out_if
);

  logic        valid_q;
  ksd_status_t status_q;

  // a new request fits when the register is empty or being drained
  assign in_ready_o = !valid_q || out_if.ready;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept_i) begin
      valid_q <= 1'b1;
    end else if (out_if.ready) begin
      valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      status_q <= status_i;
    end
  end

  assign out_if.valid        = valid_q;
  assign out_if.drive_row    = status_q.pos[POS_W-1:2];
  assign out_if.sense_column = status_q.pos[1:0];
  assign out_if.key_valid    = status_q.key_valid;
  assign out_if.key_index    = status_q.key;
  assign out_if.key_char     = hex_char(status_q.key);
  assign out_if.key_released = status_q.released;
  assign out_if.buzzer_on    = status_q.buzzer;

endmodule

`default_nettype wire

// File: rtl/keypad_scan_debounce.sv
// top level of the 4x4 keypad scanner with debounce and release detection
//
//   channel | direction | handshake      | payload
//   in_if   | sink      | valid / ready  | cmd, line_level
//   out_if  | source    | valid / ready  | drive_row, sense_column, key_valid,
//           |           |                | key_index, key_char, key_released, buzzer_on
//   apb     | slave     | psel / penable | paddr, pwdata, prdata (pready tied high)
//
// one request per cycle unless stalled; a result appears the cycle after its request
// the state update and the result register form the only stage
// in_if.ready is low only while a result is held and out_if.ready is low
// asynchronous active-low reset; registers reset to 32 ticks, no clearing pass
`default_nettype none

module keypad_scan_debounce
  import ksd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  ksd_in_if.sink                 in_if,
  ksd_out_if.source              out_if
);

  ksd_cfg_t    cfg;
  ksd_status_t status;
  logic        in_ready;
  logic        accept;

  assign in_if.ready = in_ready;
  assign accept      = in_if.valid && in_ready;

  // configuration registers
  ksd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // scan and key state
  ksd_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .accept_i     (accept),
    .cmd_i        (in_if.cmd),
    .line_level_i (in_if.line_level),
    .status_o     (status)
  );

  // result register
  ksd_result u_result (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .status_i   (status),
    .in_ready_o (in_ready),
    .out_if     (out_if)
  );

endmodule

`default_nettype wire

// File: rtl/keypad_scan_debounce_checker.sv
// port-level assertions for the keypad scanner and their bind
`default_nettype none
`include "keypad_scan_debounce_macros.svh"

module keypad_scan_debounce_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       key_valid_i,
  input wire logic [3:0] key_index_i,
  input wire logic [6:0] key_char_i,
  input wire logic       key_released_i,
  input wire logic       buzzer_on_i
);

  logic       flags_set;
  logic       stalled;
  logic [6:0] exp_char;

  assign flags_set = out_valid_i && (key_released_i || buzzer_on_i);
  assign stalled   = out_valid_i && !out_ready_i;
  assign exp_char  = (key_index_i < 4'd10) ? (7'd48 + 7'(key_index_i))
                                           : (7'd55 + 7'(key_index_i));

  // the request side never waits while no result is held
  `KSD_ASSERT(a_ready_when_empty, !out_valid_i |-> in_ready_i, "request stalled while empty")

  // released and buzzer only exist for a confirmed key
  `KSD_ASSERT(a_flags_need_key, flags_set |-> key_valid_i, "release or buzzer without key")

  // buzzer is off once release is reported
  `KSD_ASSERT(a_buzzer_off, out_valid_i && key_released_i |-> !buzzer_on_i, "buzzer on after release")

  // ascii digit follows the key index
  `KSD_ASSERT(a_char_matches, out_valid_i |-> key_char_i == exp_char, "key char mismatch")

  // a stalled result keeps its key
  `KSD_ASSERT_NEXT(a_stall_hold, stalled, out_valid_i && $stable(key_index_i), "result changed")

endmodule

bind keypad_scan_debounce keypad_scan_debounce_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_if.ready),
  .out_valid_i    (out_if.valid),
  .out_ready_i    (out_if.ready),
  .key_valid_i    (out_if.key_valid),
  .key_index_i    (out_if.key_index),
  .key_char_i     (out_if.key_char),
  .key_released_i (out_if.key_released),
  .buzzer_on_i    (out_if.buzzer_on)
);

`default_nettype wire
